### rtl/core/qap_pkg.sv
// Shared types, command codes and constant tables of the quaternion attitude PID core.
`default_nettype none
package qap_pkg;

  localparam int CNT_W = 5;

  // Command codes; the controller also uses them as its state codes.
  localparam logic [4:0] OP_IDLE  = 5'd0;
  localparam logic [4:0] OP_QMAC  = 5'd1;
  localparam logic [4:0] OP_QFIX  = 5'd2;
  localparam logic [4:0] OP_SQ    = 5'd3;
  localparam logic [4:0] OP_SQRT  = 5'd4;
  localparam logic [4:0] OP_CORD  = 5'd5;
  localparam logic [4:0] OP_ANGV  = 5'd6;
  localparam logic [4:0] OP_DIV   = 5'd7;
  localparam logic [4:0] OP_EFIN  = 5'd8;
  localparam logic [4:0] OP_ESTEP = 5'd9;
  localparam logic [4:0] OP_INT   = 5'd10;
  localparam logic [4:0] OP_KPE   = 5'd11;
  localparam logic [4:0] OP_KPI   = 5'd12;
  localparam logic [4:0] OP_PLO   = 5'd13;
  localparam logic [4:0] OP_PHI   = 5'd14;
  localparam logic [4:0] OP_ADDI  = 5'd15;
  localparam logic [4:0] OP_KDR   = 5'd16;
  localparam logic [4:0] OP_SAT   = 5'd17;
  localparam logic [4:0] OP_DONE  = 5'd18;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_GAIN_P_X = 3'd0;
  localparam logic [2:0] REG_GAIN_P_Y = 3'd1;
  localparam logic [2:0] REG_GAIN_P_Z = 3'd2;
  localparam logic [2:0] REG_GAIN_D_X = 3'd3;
  localparam logic [2:0] REG_GAIN_D_Y = 3'd4;
  localparam logic [2:0] REG_GAIN_D_Z = 3'd5;
  localparam logic [2:0] REG_LIMIT    = 3'd6;
  localparam logic [2:0] REG_STEP     = 3'd7;

  localparam int QMAC_LAST = 15;
  localparam int SQ_LAST   = 2;
  localparam int SQRT_LAST = 24;
  localparam int DIV_LAST  = 19;

  // 0.01 as 10486 / 2^20.
  localparam logic signed [26:0] ONE_HUNDREDTH = 27'sd10486;

  // Sign of each term of the Hamilton product, bit comp*4+term set when subtracted.
  localparam logic [15:0] QPROD_NEG = 16'hAC60;

  typedef struct packed {
    logic [4:0]       op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       axis;
    logic             load;
  } qap_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic out_free;
  } qap_status_t;

  typedef struct packed {
    logic [2:0][23:0] gain_p;
    logic [2:0][23:0] gain_d;
    logic [22:0]      limit;
    logic [15:0]      step;
  } qap_cfg_t;

  // atan(2^-s) in Q.30 radians, truncated.
  function automatic logic [30:0] atan_q30(input logic [4:0] s);
    logic [30:0] r;
    case (s)
      5'd0:  r = 31'h3243F6A8;
      5'd1:  r = 31'h1DAC6705;
      5'd2:  r = 31'h0FADBAFC;
      5'd3:  r = 31'h07F56EA6;
      5'd4:  r = 31'h03FEAB76;
      5'd5:  r = 31'h01FFD55B;
      5'd6:  r = 31'h00FFFAAA;
      5'd7:  r = 31'h007FFF55;
      5'd8:  r = 31'h003FFFEA;
      5'd9:  r = 31'h001FFFFD;
      5'd10: r = 31'h000FFFFF;
      5'd11: r = 31'h0007FFFF;
      5'd12: r = 31'h0003FFFF;
      5'd13: r = 31'h0001FFFF;
      5'd14: r = 31'h0000FFFF;
      5'd15: r = 31'h00007FFF;
      5'd16: r = 31'h00003FFF;
      5'd17: r = 31'h00001FFF;
      5'd18: r = 31'h00000FFF;
      5'd19: r = 31'h000007FF;
      5'd20: r = 31'h000003FF;
      5'd21: r = 31'h000001FF;
      5'd22: r = 31'h000000FF;
      5'd23: r = 31'h0000007F;
      5'd24: r = 31'h0000003F;
      5'd25: r = 31'h0000001F;
      5'd26: r = 31'h0000000F;
      5'd27: r = 31'h00000007;
      5'd28: r = 31'h00000003;
      5'd29: r = 31'h00000001;
      default: r = 31'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/qap_ctrl.sv
// Sequencer that steps the shared datapath through one attitude update.
`default_nettype none
module qap_ctrl #(
  parameter int ANGLE_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qap_pkg::qap_status_t status,
  output qap_pkg::qap_cmd_t        cmd
);
  import qap_pkg::*;

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       axis, axis_next;

  assign in_ready = (state == OP_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    axis_next  = axis;
    case (state)
      OP_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = OP_QMAC;
      end
      OP_QMAC: if (cnt == CNT_W'(QMAC_LAST)) state_next = OP_QFIX;
      OP_QFIX: begin
        cnt_next   = '0;
        state_next = OP_SQ;
      end
      OP_SQ: if (cnt == CNT_W'(SQ_LAST)) begin
        cnt_next   = '0;
        state_next = OP_SQRT;
      end
      OP_SQRT: if (cnt == CNT_W'(SQRT_LAST)) begin
        cnt_next   = '0;
        state_next = OP_CORD;
      end
      OP_CORD: if (cnt == CNT_W'(ANGLE_STEPS - 1)) begin
        axis_next  = '0;
        state_next = OP_ANGV;
      end
      OP_ANGV: begin
        cnt_next   = '0;
        state_next = status.mag_zero ? OP_EFIN : OP_DIV;
      end
      OP_DIV:   if (cnt == CNT_W'(DIV_LAST)) state_next = OP_EFIN;
      OP_EFIN:  state_next = OP_ESTEP;
      OP_ESTEP: state_next = OP_INT;
      OP_INT:   state_next = OP_KPE;
      OP_KPE:   state_next = OP_KPI;
      OP_KPI:   state_next = OP_PLO;
      OP_PLO:   state_next = OP_PHI;
      OP_PHI:   state_next = OP_ADDI;
      OP_ADDI:  state_next = OP_KDR;
      OP_KDR:   state_next = OP_SAT;
      OP_SAT: begin
        if (axis == 2'd2) begin
          state_next = OP_DONE;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = OP_ANGV;
        end
      end
      OP_DONE: if (status.out_free) state_next = OP_IDLE;
      default: state_next = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OP_IDLE;
      cnt   <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    cmd.op   = state;
    cmd.cnt  = cnt;
    cmd.axis = axis;
    cmd.load = in_ready && in_valid;
  end

endmodule
`default_nettype wire

### rtl/core/qap_dp.sv
// Datapath: shared multiplier, square root, CORDIC, divider and per-axis PID arithmetic.
`default_nettype none
module qap_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qap_pkg::qap_cmd_t   cmd,
  input  wire qap_pkg::qap_cfg_t   cfg,
  input  wire logic [175:0]        in_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [95:0]              out_data,
  output qap_pkg::qap_status_t     status
);
  import qap_pkg::*;

  logic signed [15:0] cq [8];
  logic signed [15:0] rate [3];
  logic signed [33:0] q [4];
  logic signed [25:0] w;
  logic signed [25:0] v [3];
  logic [49:0]        sq_n;
  logic [50:0]        sq_res;
  logic [24:0]        mag;
  logic signed [27:0] cx, cy;
  logic signed [32:0] ang;
  logic [57:0]        rem, dsh;
  logic [19:0]        quo;
  logic               e_neg;
  logic signed [20:0] e;
  logic signed [23:0] integ [3];
  logic signed [47:0] acc;
  logic signed [47:0] pp;
  logic signed [63:0] t;
  logic signed [31:0] trq [3];
  logic [2:0][31:0]   out_trq;

  logic signed [35:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [62:0] prod;

  logic [1:0]  comp, term;
  logic [4:0]  sh;
  assign comp = cmd.cnt[3:2];
  assign term = cmd.cnt[1:0];
  assign sh   = cmd.cnt[4:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_QMAC: begin
        mul_a = 36'(cq[term]);
        mul_b = 27'(cq[4 + (term ^ comp)]);
      end
      OP_SQ: begin
        mul_a = 36'(v[cmd.cnt[1:0]]);
        mul_b = 27'(v[cmd.cnt[1:0]]);
      end
      OP_ANGV: begin
        mul_a = 36'(ang);
        mul_b = 27'(v[cmd.axis]);
      end
      OP_ESTEP: begin
        mul_a = 36'(e);
        mul_b = $signed({11'd0, cfg.step});
      end
      OP_KPE: begin
        mul_a = $signed({12'd0, cfg.gain_p[cmd.axis]});
        mul_b = 27'(e);
      end
      OP_KPI: begin
        mul_a = $signed({12'd0, cfg.gain_p[cmd.axis]});
        mul_b = 27'(integ[cmd.axis]);
      end
      OP_PLO: begin
        mul_a = $signed({12'd0, pp[23:0]});
        mul_b = ONE_HUNDREDTH;
      end
      OP_PHI: begin
        mul_a = 36'($signed(pp[47:24]));
        mul_b = ONE_HUNDREDTH;
      end
      OP_KDR: begin
        mul_a = $signed({12'd0, cfg.gain_d[cmd.axis]});
        mul_b = 27'(rate[cmd.axis]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 63'(mul_a) * 63'(mul_b);

  // Hamilton product accumulation.
  logic signed [47:0] qmac_sum;
  assign qmac_sum = ((term == 2'd0) ? 48'sd0 : acc) +
                    (QPROD_NEG[{comp, term}] ? -48'(prod) : 48'(prod));

  // Short-path fix and rounding to Q.20.
  logic               q_flip;
  logic signed [34:0] qr [4];
  assign q_flip = q[0][33];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qr[k] = ((q_flip ? -35'(q[k]) : 35'(q[k])) + 35'sd128) >>> 8;
    end
  end

  // Integer square root by trial subtraction, from the top result bit down.
  logic [50:0] sq_bit, sq_try;
  assign sq_bit = 51'd1 << (6'd48 - {cmd.cnt, 1'b0});
  assign sq_try = sq_res + sq_bit;

  // Vectoring CORDIC.
  logic signed [27:0] xc, yc, dx, dy;
  logic signed [32:0] ac, at;
  assign xc = (cmd.cnt == '0) ? 28'(w) : cx;
  assign yc = (cmd.cnt == '0) ? $signed({3'd0, sq_res[24:0]}) : cy;
  assign ac = (cmd.cnt == '0) ? 33'sd0 : ang;
  assign dx = yc >>> sh;
  assign dy = xc >>> sh;
  assign at = $signed({2'b00, atan_q30(sh)});

  // Integral update with clamp.
  logic signed [47:0] int_r;
  logic signed [25:0] ival, lim;
  assign int_r = (acc + 48'sd524288) >>> 20;
  assign lim   = $signed({3'd0, cfg.limit});
  assign ival  = 26'(integ[cmd.axis]) + int_r[25:0];

  logic signed [63:0] t_r;
  logic signed [47:0] sat_r;
  assign t_r   = (t + 64'sd524288) >>> 20;
  assign sat_r = (acc + 48'sd2048) >>> 12;

  logic signed [62:0] num;
  assign num = prod <<< 1;

  assign status.mag_zero = (mag == '0);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 8; k++) cq[k] <= in_data[16*k +: 16];
      for (int k = 0; k < 3; k++) rate[k] <= in_data[128 + 16*k +: 16];
    end
    case (cmd.op)
      OP_QMAC: begin
        acc <= qmac_sum;
        if (term == 2'd3) q[comp] <= qmac_sum[33:0];
      end
      OP_QFIX: begin
        w <= qr[0][25:0];
        for (int k = 0; k < 3; k++) v[k] <= qr[k + 1][25:0];
      end
      OP_SQ: begin
        sq_n   <= ((cmd.cnt == '0) ? 50'd0 : sq_n) + prod[49:0];
        sq_res <= '0;
      end
      OP_SQRT: begin
        if ({1'b0, sq_n} >= sq_try) begin
          sq_n   <= sq_n - sq_try[49:0];
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
      end
      OP_CORD: begin
        if (cmd.cnt == '0) mag <= sq_res[24:0];
        if (!yc[27]) begin
          cx  <= xc + dx;
          cy  <= yc - dy;
          ang <= ac + at;
        end else begin
          cx  <= xc - dx;
          cy  <= yc + dy;
          ang <= ac - at;
        end
      end
      OP_ANGV: begin
        e_neg <= num[62];
        rem   <= num[62] ? 58'(-num) : num[57:0];
        dsh   <= {mag, 33'd0};
        quo   <= '0;
      end
      OP_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[18:0], 1'b1};
        end else begin
          quo <= {quo[18:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      OP_EFIN: begin
        if (status.mag_zero) e <= '0;
        else e <= e_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      end
      OP_ESTEP: acc <= prod[47:0];
      OP_INT: begin
        if (ival > lim)       integ[cmd.axis] <= lim[23:0];
        else if (ival < -lim) integ[cmd.axis] <= 24'(-lim);
        else                  integ[cmd.axis] <= ival[23:0];
      end
      OP_KPE:  acc <= prod[47:0];
      OP_KPI:  pp  <= prod[47:0];
      OP_PLO:  t   <= 64'(prod);
      OP_PHI:  t   <= t + (64'(prod) <<< 24);
      OP_ADDI: acc <= acc + t_r[47:0];
      OP_KDR:  acc <= acc - (48'(prod) <<< 4);
      OP_SAT: begin
        if (sat_r > 48'sh0000_7FFF_FFFF)      trq[cmd.axis] <= 32'sh7FFF_FFFF;
        else if (sat_r < -48'sh0000_8000_0000) trq[cmd.axis] <= 32'sh8000_0000;
        else                                  trq[cmd.axis] <= sat_r[31:0];
      end
      OP_DONE: begin
        if (status.out_free) begin
          for (int k = 0; k < 3; k++) out_trq[k] <= trq[k];
        end
      end
      default: ;
    endcase
    if (rst) begin
      for (int k = 0; k < 3; k++) integ[k] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_DONE && status.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = out_trq;

endmodule
`default_nettype wire

### rtl/core/quaternion_attitude_pid_core.sv
// Quaternion attitude PID core: configuration registers, controller and datapath.
// Each input word is worked through to its output word before the next one is taken; the
// three divides are skipped when the error has no vector part, which shortens the update.
// A finished output word waits in its register while the next input word is taken and
// processed, and the core holds in its last step until that register is free.
// Reset clears gains, limit, step time, the three integrals and the output valid flag.
`default_nettype none
module quaternion_attitude_pid_core #(
  parameter int ANGLE_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // cur_w, cur_x, cur_y, cur_z, tgt_w, tgt_x, tgt_y, tgt_z, rate_x, rate_y, rate_z
  input  wire logic [175:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // torque_x, torque_y, torque_z
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);
  import qap_pkg::*;

  qap_cfg_t    cfg;
  qap_cmd_t    cmd;
  qap_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P_X: cfg.gain_p[0] <= cfg_data;
        REG_GAIN_P_Y: cfg.gain_p[1] <= cfg_data;
        REG_GAIN_P_Z: cfg.gain_p[2] <= cfg_data;
        REG_GAIN_D_X: cfg.gain_d[0] <= cfg_data;
        REG_GAIN_D_Y: cfg.gain_d[1] <= cfg_data;
        REG_GAIN_D_Z: cfg.gain_d[2] <= cfg_data;
        REG_LIMIT:    cfg.limit     <= cfg_data[22:0];
        REG_STEP:     cfg.step      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  qap_ctrl #(.ANGLE_STEPS(ANGLE_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  qap_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .status    (status)
  );

endmodule
`default_nettype wire

### rtl/core/qap_checker.sv
// Port-level checks of the attitude core, bound to the top level.
`default_nettype none
module qap_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [95:0]  m_axis_tdata
);

  // An accepted word leaves the core busy, so it does not take input again right away.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an accepted word");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("core not idle after reset");

  // An output word never shows up in the cycle right after an input is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output word appeared too early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

endmodule

bind quaternion_attitude_pid_core qap_checker u_qap_checker (.*);
`default_nettype wire

### test/tb_quaternion_attitude_pid_core.sv
// Testbench for the quaternion attitude PID core: directed and randomized stream traffic checked against a predictor.
`default_nettype none
module tb_quaternion_attitude_pid_core;
  import qap_pkg::*;

  localparam int N_RANDOM = 1625;
  localparam int LATENCY  = 155;
  localparam int CYC_MAX  = 2_000_000;

  typedef struct packed {
    logic signed [15:0] rate_z, rate_y, rate_x;
    logic signed [15:0] tgt_z, tgt_y, tgt_x, tgt_w;
    logic signed [15:0] cur_z, cur_y, cur_x, cur_w;
  } attitude_word_t;

  typedef struct packed {
    logic signed [31:0] torque_z, torque_y, torque_x;
  } torque_word_t;

  // Predicts the commanded torque and keeps the expected words in order.
  class torque_scoreboard;
    logic [23:0] kp[3];
    logic [23:0] kd[3];
    logic [22:0] limit;
    logic [15:0] step;
    longint integ[3];
    torque_word_t pending[$];
    int errors;

    function new();
      for (int k = 0; k < 3; k++) begin
        kp[k] = 0; kd[k] = 0; integ[k] = 0;
      end
      limit = 0; step = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_GAIN_P_X, REG_GAIN_P_Y, REG_GAIN_P_Z: kp[idx] = val;
        REG_GAIN_D_X, REG_GAIN_D_Y, REG_GAIN_D_Z: kd[idx - REG_GAIN_D_X] = val;
        REG_LIMIT: limit = val[22:0];
        default: step = val[15:0];
      endcase
    endfunction

    // Floor shift and round half up, both on signed 64-bit values.
    function longint fsh(longint v, int s);
      return v >>> s;
    endfunction

    function longint rhu(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint root(longint n);
      longint r, b;
      r = 0; b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b); r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_input(attitude_word_t a);
      longint cw, cx, cy, cz, tw, tx, ty, tz;
      longint q[4];
      longint e[3];
      longint r[3];
      longint mag, x, y, ang, dx, dy, iv, acc, lim;
      torque_word_t t;
      cw = longint'(a.cur_w); cx = longint'(a.cur_x);
      cy = longint'(a.cur_y); cz = longint'(a.cur_z);
      tw = longint'(a.tgt_w); tx = longint'(a.tgt_x);
      ty = longint'(a.tgt_y); tz = longint'(a.tgt_z);
      r[0] = longint'(a.rate_x); r[1] = longint'(a.rate_y); r[2] = longint'(a.rate_z);
      q[0] = cw*tw + cx*tx + cy*ty + cz*tz;
      q[1] = cw*tx - cx*tw - cy*tz + cz*ty;
      q[2] = cw*ty + cx*tz - cy*tw - cz*tx;
      q[3] = cw*tz - cx*ty + cy*tx - cz*tw;
      if (q[0] < 0) for (int k = 0; k < 4; k++) q[k] = -q[k];
      for (int k = 0; k < 4; k++) q[k] = rhu(q[k], 8);
      mag = root(q[1]*q[1] + q[2]*q[2] + q[3]*q[3]);
      x = q[0]; y = mag; ang = 0;
      for (int i = 0; i < 16; i++) begin
        dx = fsh(y, i); dy = fsh(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; ang += longint'(atan_q30(i[4:0]));
        end else begin
          x -= dx; y += dy; ang -= longint'(atan_q30(i[4:0]));
        end
      end
      lim = longint'(limit);
      for (int k = 0; k < 3; k++) begin
        // SystemVerilog division truncates toward zero, as required here.
        e[k] = (mag == 0) ? 0 : (2 * ang * q[k+1]) / (mag * 16384);
        iv = integ[k] + rhu(e[k] * longint'(step), 20);
        if (iv > lim) iv = lim;
        if (iv < -lim) iv = -lim;
        integ[k] = iv;
        acc = longint'(kp[k]) * e[k];
        acc += rhu(longint'(kp[k]) * iv * 10486, 20);
        acc -= 16 * (longint'(kd[k]) * r[k]);
        acc = rhu(acc, 12);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        case (k)
          0: t.torque_x = acc[31:0];
          1: t.torque_y = acc[31:0];
          default: t.torque_z = acc[31:0];
        endcase
      end
      pending.push_back(t);
    endfunction

    function void check_result(torque_word_t got);
      torque_word_t exp_t;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      exp_t = pending.pop_front();
      if (got.torque_x !== exp_t.torque_x) begin
        $error("torque_x expected %0d actual %0d", exp_t.torque_x, got.torque_x); errors++;
      end
      if (got.torque_y !== exp_t.torque_y) begin
        $error("torque_y expected %0d actual %0d", exp_t.torque_y, got.torque_y); errors++;
      end
      if (got.torque_z !== exp_t.torque_z) begin
        $error("torque_z expected %0d actual %0d", exp_t.torque_z, got.torque_z); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  torque_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int received = 0;
  bit hold_off = 0;

  always #2 clk = ~clk;

  quaternion_attitude_pid_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_MAX) begin
      $display("quaternion_attitude_pid_core test failed");
      $finish;
    end
  end

  // Receiver: random stalls per word, with a long hold-off in each random phase while the sender keeps going.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (2000) @(negedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata);
      received++;
      @(negedge clk);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_word(attitude_word_t a, bit random_gap);
    int gap;
    gap = random_gap ? $urandom_range(0, 19) : 0;
    if (gap > 0 && $urandom_range(0, 3) != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= a;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(a);
    sent++;
    @(negedge clk);
    s_axis_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
  endtask

  function automatic logic signed [15:0] qpart(int mode);
    case (mode)
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return $signed(16'($urandom_range(0, 32768) - 16384));
    endcase
  endfunction

  // Random word: random parts in range, mostly with a smaller current vector part; some targets copy the current.
  function automatic attitude_word_t rand_word();
    attitude_word_t a;
    int m;
    m = $urandom_range(0, 9);
    a.cur_w = qpart(m < 2 ? $urandom_range(0, 3) : 3);
    a.cur_x = qpart(3); a.cur_y = qpart(3); a.cur_z = qpart(3);
    if (m < 6) begin
      a.cur_x = a.cur_x >>> 2; a.cur_y = a.cur_y >>> 2; a.cur_z = a.cur_z >>> 2;
    end
    a.tgt_w = qpart(m == 9 ? $urandom_range(0, 2) : 3);
    a.tgt_x = qpart(3); a.tgt_y = qpart(3); a.tgt_z = qpart(3);
    if (m == 8) begin
      a.tgt_w = a.cur_w; a.tgt_x = a.cur_x; a.tgt_y = a.cur_y; a.tgt_z = a.cur_z;
    end
    a.rate_x = 16'($urandom); a.rate_y = 16'($urandom); a.rate_z = 16'($urandom);
    return a;
  endfunction

  function automatic attitude_word_t make_word(int cw, int cx, int cy, int cz,
                                               int tw, int tx, int ty, int tz, int r);
    attitude_word_t a;
    a.cur_w = 16'(cw); a.cur_x = 16'(cx); a.cur_y = 16'(cy); a.cur_z = 16'(cz);
    a.tgt_w = 16'(tw); a.tgt_x = 16'(tx); a.tgt_y = 16'(ty); a.tgt_z = 16'(tz);
    a.rate_x = 16'(r); a.rate_y = 16'(-r); a.rate_z = 16'(r);
    return a;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && n > 100) hold_off = 1;
      send_word(rand_word(), 1);
    end
  endtask

  initial begin
    logic [23:0] vals[4];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Gains are zero after reset, so the torque must be zero.
    send_word(make_word(16384, 0, 0, 0, 0, 16384, 0, 0, 32767), 0);
    drain();

    write_cfg(REG_GAIN_P_X, 24'h001000); write_cfg(REG_GAIN_P_Y, 24'hFFFFFF);
    write_cfg(REG_GAIN_P_Z, 24'h004000); write_cfg(REG_GAIN_D_X, 24'h000800);
    write_cfg(REG_GAIN_D_Y, 24'hFFFFFF); write_cfg(REG_GAIN_D_Z, 24'h000000);
    write_cfg(REG_LIMIT, 24'h7FFFFF); write_cfg(REG_STEP, 24'h00FFFF);

    // Identity error, opposite attitudes, extreme rates, non-unit parts.
    send_word(make_word(16384, 0, 0, 0, 16384, 0, 0, 0, 0), 0);
    send_word(make_word(16384, 0, 0, 0, 0, 16384, 0, 0, 4096), 0);
    send_word(make_word(0, 0, 16384, 0, 0, 0, -16384, 0, -4096), 0);
    send_word(make_word(-16384, 0, 0, 0, 16384, 0, 0, 0, 32767), 0);
    send_word(make_word(16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384,
                        -32768), 0);
    send_word(make_word(16384, -16384, 16384, -16384, 16384, 16384, -16384, 16384,
                        32767), 0);
    send_word(make_word(-16384, -16384, -16384, -16384, 16384, 16384, 16384, 16384,
                        -32768), 0);
    send_word(make_word(11585, 11585, 0, 0, 11585, 0, 11585, 0, 1), 0);
    send_word(make_word(1, 0, 0, 0, 0, 0, 0, 1, -1), 0);
    send_word(make_word(16384, 0, 0, 0, -11585, 0, 0, 11585, 100), 0);
    for (int i = 0; i < 6; i++) send_word(make_word(16384, 0, 0, 0, 0, 0, 16384, 0, 0), 0);
    drain();

    // Zero step time adds nothing to the integrals; the smaller limit clamps them.
    write_cfg(REG_STEP, 24'h000000);
    write_cfg(REG_LIMIT, 24'h000100);
    for (int i = 0; i < 5; i++) send_word(rand_word(), 0);
    drain();

    vals[0] = 24'h000000; vals[1] = 24'hFFFFFF; vals[2] = 24'h001000;
    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < 6; r++)
        write_cfg(r[2:0], ph == 0 ? vals[1] : ph == 1 ? vals[0] :
                  ph == 2 ? vals[2] : 24'($urandom));
      write_cfg(REG_LIMIT, ph == 0 ? 24'h7FFFFF : ph == 1 ? 24'h0 : 24'($urandom_range(0, 8388607)));
      write_cfg(REG_STEP, ph == 1 ? 24'hFFFF : 24'($urandom_range(0, 65535)));
      random_phase(ph == 4 ? N_RANDOM - 4 * 300 : 300);
      drain();
    end

    $display("Covered %0d input words and %0d torque words across several gain, limit and",
             sent, received);
    $display("step settings, including zero gains, saturation and a long output stall.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("quaternion_attitude_pid_core test passed");
    else
      $display("quaternion_attitude_pid_core test failed");
    $finish;
  end
endmodule
`default_nettype wire
